>>> src/cmstd_pkg.sv
package cmstd_pkg;

  localparam int NUM_VARS    = 16;
  localparam int MAX_VECTORS = 4096;
  localparam int VAR_LIMIT   = (NUM_VARS < 16) ? NUM_VARS : 16;

  localparam int VAR_W      = 4;
  localparam int ACT_W      = 5;
  localparam int SAMPLE_W   = 24;
  localparam int SQR_W      = 2 * SAMPLE_W;
  localparam int SUM_W      = 37;
  localparam int SQ_W       = 59;
  localparam int CNT_W      = 13;
  localparam int MEAN_W     = 24;
  localparam int STD_W      = 23;
  localparam int ROOT_W     = 30;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int DIV_W      = SQ_W;
  localparam int DIV_STEP_W = $clog2(DIV_W);
  localparam int ROOT_STEP_W = $clog2(ROOT_W);

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [MEAN_W-1:0] MEAN_POS_MAX = MEAN_W'(8388607);
  localparam logic [MEAN_W-1:0] MEAN_NEG_MAG = MEAN_W'(8388608);
  localparam logic [STD_W-1:0]  STD_MAX      = STD_W'(8388607);

  localparam logic MODE_ACC    = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // register index, decoded from paddr[2]
  localparam logic REG_ACTIVE_VARS = 1'b0;

  typedef struct packed {
    logic                       mode;
    logic [VAR_W-1:0]           var_index;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [VAR_W-1:0]         out_var;
    logic signed [MEAN_W-1:0] mean_value;
    logic [STD_W-1:0]         std_value;
    logic                     no_data;
    logic                     overflowed;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic                       finish;
    logic [VAR_W-1:0]           var_index;
    logic signed [SAMPLE_W-1:0] sample;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

endpackage

>>> src/column_mean_std.sv
// Channel   Ports                                  Beat
// in        in_valid, in_stall, in_data            one sample or one finish command
// out       out_valid, out_stall, out_data         statistics of one variable
// config    psel, penable, pwrite, paddr, pwdata,  active_vars at byte address 0
//           prdata, pready
//
// Samples are taken one per cycle while in_stall is low; a four-deep queue separates
// intake from the accumulator, whose read-modify-write of the per-variable sums runs
// at one a cycle outside a finish walk. A finish command walks the active variables
// on one shared restoring divider (mean, then mean of squares) and a root unit, or
// skips both units for every variable when no vector was counted.
// Synchronous active-low reset clears control state and all accumulators.
// out_stall holds the output register; the queue fills and raises in_stall.
module column_mean_std (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  cmstd_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cmstd_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import cmstd_pkg::*;

  logic [ACT_W-1:0] active_vars_r;
  logic [VAR_W-1:0] last_var;
  logic             cfg_wr;
  q_head_t          head;
  logic             pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_vars_r <= ACT_W'(16);
    end else if (cfg_wr && (paddr[2] == REG_ACTIVE_VARS)) begin
      active_vars_r <= pwdata[ACT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ACTIVE_VARS) ? 32'(active_vars_r) : '0;

  // zero counts as one variable, anything above the limit as the limit
  always_comb begin
    priority if (active_vars_r == '0) begin
      last_var = '0;
    end else if (active_vars_r > ACT_W'(VAR_LIMIT)) begin
      last_var = VAR_W'(VAR_LIMIT - 1);
    end else begin
      last_var = VAR_W'(active_vars_r - ACT_W'(1));
    end
  end

  cmstd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .last_var (last_var),
    .head     (head),
    .pop      (pop)
  );

  cmstd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .last_var  (last_var),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> src/cmstd_front.sv
module cmstd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  cmstd_pkg::in_item_t       in_data,
  input  logic [cmstd_pkg::VAR_W-1:0] last_var,
  output cmstd_pkg::q_head_t        head,
  input  logic                      pop
);
  import cmstd_pkg::*;

  op_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              keep;
  logic              push;
  op_t               op_in;

  // drop samples of inactive variables here, they never reach the back end
  assign keep     = (in_data.mode == MODE_FINISH) || (in_data.var_index <= last_var);
  assign in_stall = (cnt_r == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall && keep;

  assign op_in.finish    = (in_data.mode == MODE_FINISH);
  assign op_in.var_index = in_data.var_index;
  assign op_in.sample    = in_data.sample_value;

  assign head.valid = (cnt_r != '0);
  assign head.op    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= op_in;
    end
  end

endmodule

>>> src/cmstd_div.sv
module cmstd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [cmstd_pkg::DIV_W-1:0] dividend,
  input  logic [cmstd_pkg::CNT_W-1:0] divisor,
  output logic                        done,
  output logic [cmstd_pkg::DIV_W-1:0] quotient
);
  import cmstd_pkg::*;

  logic                  busy_r, done_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [DIV_W-1:0]      quo_r;
  logic [CNT_W-1:0]      rem_r;
  logic [CNT_W-1:0]      dvs_r;
  logic [CNT_W:0]        rem_sh;
  logic                  ge;
  logic [CNT_W:0]        rem_sub;

  // restoring division, one quotient bit a cycle shifted in behind the dividend
  assign rem_sh  = {rem_r, quo_r[DIV_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_r});
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + DIV_STEP_W'(1);
        if (step_r == DIV_STEP_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
  end

endmodule

>>> src/cmstd_sqrt.sv
module cmstd_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [cmstd_pkg::RAD_W-1:0]  radicand,
  output logic                         done,
  output logic [cmstd_pkg::ROOT_W-1:0] root
);
  import cmstd_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic                   busy_r, done_r;
  logic [ROOT_STEP_W-1:0] step_r;
  logic [RAD_W-1:0]       rad_r;
  logic [REM_W-1:0]       rem_r;
  logic [ROOT_W-1:0]      root_r;
  logic [REM_W+1:0]       rem_sh;
  logic [REM_W+1:0]       trial;
  logic [REM_W+1:0]       rem_sub;
  logic                   ge;

  // digit-by-digit root: bring down two radicand bits, try 4*root+1
  assign rem_sh  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial   = {2'b00, root_r, 2'b01};
  assign ge      = (rem_sh >= trial);
  assign rem_sub = rem_sh - trial;

  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + ROOT_STEP_W'(1);
        if (step_r == ROOT_STEP_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

endmodule

>>> src/cmstd_back.sv
module cmstd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmstd_pkg::q_head_t          head,
  output logic                        pop,
  input  logic [cmstd_pkg::VAR_W-1:0] last_var,
  output logic                        out_valid,
  input  logic                        out_stall,
  output cmstd_pkg::out_item_t        out_data
);
  import cmstd_pkg::*;

  typedef enum logic [8:0] {
    S_RUN       = 9'b000000001,
    S_SUM_GO    = 9'b000000010,
    S_SUM_WAIT  = 9'b000000100,
    S_SQ_GO     = 9'b000001000,
    S_SQ_WAIT   = 9'b000010000,
    S_MUL       = 9'b000100000,
    S_ROOT_GO   = 9'b001000000,
    S_ROOT_WAIT = 9'b010000000,
    S_EMIT      = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SUM_W-1:0] sum_r [NUM_VARS];
  logic [SQ_W-1:0]  sq_r  [NUM_VARS];
  logic [CNT_W-1:0] count_r;
  logic             ovf_r;

  // multiply stage of the accumulate path
  logic                       s1_valid_r;
  logic [VAR_W-1:0]           s1_var_r;
  logic signed [SAMPLE_W-1:0] s1_x_r;
  logic [SQR_W-1:0]           s1_sq_r;
  logic signed [SQR_W-1:0]    sq_full;

  logic [VAR_W-1:0]  v_r;
  logic              neg_r;
  logic [MEAN_W-1:0] mag_r;
  logic [MEAN_W-1:0] mean_r;
  logic [SQ_W-1:0]   msq_r;
  logic [SQR_W-1:0]  m2_r;
  logic [STD_W-1:0]  std_r;

  logic              out_valid_r;
  out_item_t         out_r;

  logic [VAR_W-1:0]  rd_addr;
  logic [SUM_W-1:0]  sum_rd;
  logic [SQ_W-1:0]   sq_rd;
  logic [SUM_W-1:0]  sum_mag;
  logic              pop_sample, pop_finish;
  logic              at_cap;
  logic              acc_wr;
  logic              clear_all;
  logic              emit_fire;
  logic              out_free;
  logic              no_data;
  logic              is_last;

  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic              div_done;
  logic [DIV_W-1:0]  div_quo;
  logic              root_start;
  logic [RAD_W-1:0]  radicand;
  logic              root_done;
  logic [ROOT_W-1:0] root;
  logic [MEAN_W-1:0] mag_lim;
  logic [MEAN_W-1:0] mag_clamp;
  logic [SQ_W-1:0]   m2_ext;

  assign no_data = (count_r == '0);
  assign is_last = (v_r == last_var);
  assign out_free = !out_valid_r || !out_stall;

  // one read port: accumulate address while running, variable walk otherwise
  assign rd_addr = (state_r == S_RUN) ? s1_var_r : v_r;
  assign sum_rd  = sum_r[rd_addr];
  assign sq_rd   = sq_r[rd_addr];
  assign sum_mag = sum_rd[SUM_W-1] ? (SUM_W'(0) - sum_rd) : sum_rd;

  assign pop_sample = (state_r == S_RUN) && head.valid && !head.op.finish;
  assign pop_finish = (state_r == S_RUN) && head.valid && head.op.finish && !s1_valid_r;
  assign pop        = pop_sample || pop_finish;

  assign sq_full = head.op.sample * head.op.sample;

  assign at_cap = (count_r == CNT_W'(MAX_VECTORS));
  assign acc_wr = s1_valid_r && !at_cap;

  assign emit_fire = (state_r == S_EMIT) && out_free;
  assign clear_all = emit_fire && is_last;

  assign div_start    = (state_r == S_SUM_GO) || (state_r == S_SQ_GO);
  assign div_dividend = (state_r == S_SUM_GO) ? DIV_W'(sum_mag) : sq_rd;

  assign m2_ext     = SQ_W'(m2_r);
  assign root_start = (state_r == S_ROOT_GO);
  assign radicand   = (msq_r > m2_ext) ? RAD_W'(msq_r - m2_ext) : '0;

  assign mag_lim   = neg_r ? MEAN_NEG_MAG : MEAN_POS_MAX;
  assign mag_clamp = (div_quo > DIV_W'(mag_lim)) ? mag_lim : div_quo[MEAN_W-1:0];

  cmstd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  cmstd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_RUN: begin
        if (pop_finish) begin
          state_nxt = no_data ? S_EMIT : S_SUM_GO;
        end
      end
      S_SUM_GO:   state_nxt = S_SUM_WAIT;
      S_SUM_WAIT: begin
        if (div_done) begin
          state_nxt = S_SQ_GO;
        end
      end
      S_SQ_GO:    state_nxt = S_SQ_WAIT;
      S_SQ_WAIT: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:      state_nxt = S_ROOT_GO;
      S_ROOT_GO:  state_nxt = S_ROOT_WAIT;
      S_ROOT_WAIT: begin
        if (root_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          if (is_last) begin
            state_nxt = S_RUN;
          end else if (no_data) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_SUM_GO;
          end
        end
      end
      default:    state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      s1_valid_r  <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_VARS; i++) begin
        sum_r[i] <= '0;
        sq_r[i]  <= '0;
      end
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= pop_sample;

      if (s1_valid_r && at_cap) begin
        ovf_r <= 1'b1;
      end
      if (acc_wr) begin
        sum_r[s1_var_r] <= sum_rd + {{(SUM_W-SAMPLE_W){s1_x_r[SAMPLE_W-1]}}, s1_x_r};
        sq_r[s1_var_r]  <= sq_rd + SQ_W'(s1_sq_r);
        if (s1_var_r == last_var) begin
          count_r <= count_r + CNT_W'(1);
        end
      end

      if (pop_finish) begin
        v_r <= '0;
      end else if (emit_fire) begin
        v_r <= v_r + VAR_W'(1);
      end

      if (emit_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (clear_all) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        for (int i = 0; i < NUM_VARS; i++) begin
          sum_r[i] <= '0;
          sq_r[i]  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_sample) begin
      s1_var_r <= head.op.var_index;
      s1_x_r   <= head.op.sample;
      s1_sq_r  <= sq_full;
    end
    if (pop_finish) begin
      mean_r <= '0;
      std_r  <= '0;
    end
    if (state_r == S_SUM_GO) begin
      neg_r <= sum_rd[SUM_W-1];
    end
    if ((state_r == S_SUM_WAIT) && div_done) begin
      mag_r  <= mag_clamp;
      mean_r <= neg_r ? (MEAN_W'(0) - mag_clamp) : mag_clamp;
    end
    if ((state_r == S_SQ_WAIT) && div_done) begin
      msq_r <= div_quo;
    end
    if (state_r == S_MUL) begin
      m2_r <= mag_r * mag_r;
    end
    if ((state_r == S_ROOT_WAIT) && root_done) begin
      std_r <= (root > ROOT_W'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];
    end
    if (emit_fire) begin
      out_r.out_var    <= v_r;
      out_r.mean_value <= mean_r;
      out_r.std_value  <= std_r;
      out_r.no_data    <= no_data;
      out_r.overflowed <= ovf_r;
      out_r.last       <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
